// ===== design/ackermann_steering_solver_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Ackermann steering solver
// These macros wrap the concurrent checks that are clocked on clk and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef ACKERMANN_STEERING_SOLVER_ASSERT_SVH
`define ACKERMANN_STEERING_SOLVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACKSS_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("ackss check failed");

// The consequent must hold in the cycle after the antecedent.
`define ACKSS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("ackss check failed");

`endif

// ===== design/ackss_pkg.sv =====
// ----------------------------------------------------------------------------
// Ackermann steering solver package
// Shared constants, register codes and the sideband type of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ackss_pkg;

	localparam int ANG_W = 34;
	localparam int ATAN_LEN = 24;

	typedef enum logic [0:0] {
		REG_AXLE_OFFSET,
		REG_TRACK_OFFSET
	} cfg_reg_t;

	localparam logic [11:0] AXLE_OFFSET_RST = 12'd236;
	localparam logic [11:0] TRACK_OFFSET_RST = 12'd289;

	localparam logic signed [10:0] STEER_MAX = 11'sd900;
	localparam logic signed [10:0] STEER_MIN = -11'sd900;

	// Tenths of a degree to binary angle: q * mag + floor((r * mag + bias) / 225).
	localparam logic [20:0] Z_SCALE_Q = 21'd1193046;
	localparam logic [6:0] Z_SCALE_R = 7'd106;
	localparam logic [6:0] Z_BIAS = 7'd112;
	localparam logic [24:0] Z_RECIP = 25'd19088744;

	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic [8:0] DEG_SCALE = 9'd360;
	localparam logic [40:0] DEG_HALF = 41'h0_8000_0000;
	localparam logic [7:0] SERVO_CENTER = 8'd90;
	localparam logic [7:0] SPEED_SAT = 8'd255;

	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic       straight;
		logic       neg;
		logic [7:0] thr;
	} meta_t;

endpackage

`default_nettype wire

// ===== design/ackss_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Steering command channel
// Carries one steering request: angle and throttle, with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ackss_cmd_if;
	logic              valid;
	logic              ready;
	logic signed [10:0] steer_angle;
	logic [7:0]        throttle;

	modport source (output valid, output steer_angle, output throttle, input ready);
	modport sink (input valid, input steer_angle, input throttle, output ready);
endinterface

`default_nettype wire

// ===== design/ackss_res_if.sv =====
// ----------------------------------------------------------------------------
// Steering result channel
// Carries the four servo positions and the two motor duties of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ackss_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] front_left_servo;
	logic [7:0] front_right_servo;
	logic [7:0] back_left_servo;
	logic [7:0] back_right_servo;
	logic [7:0] left_duty;
	logic [7:0] right_duty;

	modport source (output valid, output front_left_servo, output front_right_servo,
		output back_left_servo, output back_right_servo, output left_duty,
		output right_duty, input ready);
	modport sink (input valid, input front_left_servo, input front_right_servo,
		input back_left_servo, input back_right_servo, input left_duty,
		input right_duty, output ready);
endinterface

`default_nettype wire

// ===== design/ackss_rotate.sv =====
// ----------------------------------------------------------------------------
// Steering angle front end
// Clamps the angle, converts it to a binary angle, runs the rotation CORDIC
// and forms the two wheel vectors scaled by the sine.
// ----------------------------------------------------------------------------
`default_nettype none

module ackss_rotate import ackss_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_ITERATIONS = 16,
	localparam int XW = FRAC_BITS + 3,
	localparam int PW = XW + 13,
	localparam int VIN_W = PW + 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [10:0]      steer_angle,
	input  wire logic [7:0]              throttle,
	input  wire logic [11:0]             axle_offset,
	input  wire logic [11:0]             track_offset,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output meta_t                        out_meta,
	output logic signed [VIN_W-1:0]      lx,
	output logic signed [VIN_W-1:0]      rx,
	output logic signed [VIN_W-1:0]      yv
);

	localparam int NI = CORDIC_ITERATIONS;
	localparam int NS = NI + 5;
	localparam int CS = 2;
	localparam int SG = NI + 2;
	localparam int PR = NI + 3;
	localparam int SM = NI + 4;
	localparam logic signed [XW-1:0] XW_ONE = XW'(1) << FRAC_BITS;

	logic [NS-1:0] v;
	logic [NS:0]   rdy;
	meta_t         meta_s [NS];
	meta_t         meta_sg;

	logic signed [10:0] theta_c;
	logic [9:0]         mag0;
	logic [16:0]        b0;
	logic [30:0]        m10;
	logic [16:0]        b_s1;
	logic [30:0]        m1_s1;
	logic [41:0]        bq;
	logic [30:0]        zsum;
	logic signed [ANG_W-1:0] z_s2;

	logic signed [XW-1:0]    rx_s [NI];
	logic signed [XW-1:0]    ry_s [NI];
	logic signed [ANG_W-1:0] rz_s [NI];

	logic signed [XW-1:0] yf;
	logic signed [XW-1:0] c_s;
	logic signed [XW-1:0] s_s;
	logic signed [PW-1:0] plc_s;
	logic signed [PW-1:0] pls_s;
	logic signed [PW-1:0] pws_s;
	logic signed [VIN_W-1:0] lx_s;
	logic signed [VIN_W-1:0] rx_s2;
	logic signed [VIN_W-1:0] yv_s;

	// A stage takes a new entry when it is empty or the next one moves on.
	assign rdy[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_rdy
		assign rdy[k] = ~v[k] | rdy[k+1];
	end
	assign in_ready = rdy[0];
	assign out_valid = v[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (rdy[0]) v[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				if (rdy[i]) v[i] <= v[i-1];
			end
		end
	end

	always_comb begin
		if (steer_angle > STEER_MAX) theta_c = STEER_MAX;
		else if (steer_angle < STEER_MIN) theta_c = STEER_MIN;
		else theta_c = steer_angle;
		mag0 = theta_c[10] ? 10'(-theta_c) : 10'(theta_c);
	end

	assign b0 = mag0 * Z_SCALE_R + Z_BIAS;
	assign m10 = mag0 * Z_SCALE_Q;
	assign bq = b_s1 * Z_RECIP;
	assign zsum = m1_s1 + 31'(bq[41:32]);
	assign yf = ry_s[NI-1];

	// A sine that comes out as zero is handled like straight ahead.
	always_comb begin
		meta_sg = meta_s[SG-1];
		if (yf == '0) meta_sg.straight = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			meta_s[0] <= '{straight: (theta_c == 11'sd0), neg: theta_c[10], thr: throttle};
			b_s1 <= b0;
			m1_s1 <= m10;
		end
		for (int i = 1; i < NS; i++) begin
			if (rdy[i]) meta_s[i] <= (i == SG) ? meta_sg : meta_s[i-1];
		end
		if (rdy[1]) z_s2 <= $signed(ANG_W'(zsum));
		if (rdy[SG]) begin
			c_s <= rx_s[NI-1];
			s_s <= meta_s[SG-1].neg ? -yf : yf;
		end
		if (rdy[PR]) begin
			plc_s <= $signed({1'b0, axle_offset}) * c_s;
			pls_s <= $signed({1'b0, axle_offset}) * s_s;
			pws_s <= $signed({1'b0, track_offset}) * s_s;
		end
		if (rdy[SM]) begin
			lx_s <= plc_s + pws_s;
			rx_s2 <= plc_s - pws_s;
			yv_s <= pls_s;
		end
	end

	for (genvar j = 0; j < NI; j++) begin : g_rot
		logic signed [XW-1:0]    xi;
		logic signed [XW-1:0]    yi;
		logic signed [ANG_W-1:0] zi;
		logic signed [ANG_W-1:0] at;
		if (j == 0) begin : g_first
			assign xi = XW_ONE;
			assign yi = '0;
			assign zi = z_s2;
		end else begin : g_next
			assign xi = rx_s[j-1];
			assign yi = ry_s[j-1];
			assign zi = rz_s[j-1];
		end
		assign at = $signed({{(ANG_W-32){1'b0}}, ATAN_TAB[j]});
		always_ff @(posedge clk) begin
			if (rdy[CS+j]) begin
				if (!zi[ANG_W-1]) begin
					rx_s[j] <= xi - (yi >>> j);
					ry_s[j] <= yi + (xi >>> j);
					rz_s[j] <= zi - at;
				end else begin
					rx_s[j] <= xi + (yi >>> j);
					ry_s[j] <= yi - (xi >>> j);
					rz_s[j] <= zi + at;
				end
			end
		end
	end

	assign out_meta = meta_s[NS-1];
	assign lx = lx_s;
	assign rx = rx_s2;
	assign yv = yv_s;

endmodule

`default_nettype wire

// ===== design/ackss_vector.sv =====
// ----------------------------------------------------------------------------
// Wheel vector CORDIC
// Folds each wheel vector into the right half plane and runs two vectoring
// CORDIC lanes side by side for the wheel angles and magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module ackss_vector import ackss_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_ITERATIONS = 16,
	localparam int VIN_W = FRAC_BITS + 17,
	localparam int VW = VIN_W + 3
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire meta_t                  in_meta,
	input  wire logic signed [VIN_W-1:0] lx,
	input  wire logic signed [VIN_W-1:0] rx,
	input  wire logic signed [VIN_W-1:0] yv,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output meta_t                       out_meta,
	output logic signed [ANG_W-1:0]     ang [2],
	output logic [VW-1:0]               mag [2]
);

	localparam int NI = CORDIC_ITERATIONS;
	localparam int NS = NI + 2;

	logic [NS-1:0] v;
	logic [NS:0]   rdy;
	meta_t         meta_s [NS];

	logic signed [VW-1:0]    vx_s [2][NI+1];
	logic signed [VW-1:0]    vy_s [2][NI+1];
	logic signed [ANG_W-1:0] vz_s [2][NI+1];
	logic                    xz_s [2][NI+1];
	logic                    yz_s [2][NI+1];
	logic signed [ANG_W-1:0] ang_s [2];
	logic [VW-1:0]           mag_s [2];

	assign rdy[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_rdy
		assign rdy[k] = ~v[k] | rdy[k+1];
	end
	assign in_ready = rdy[0];
	assign out_valid = v[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (rdy[0]) v[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				if (rdy[i]) v[i] <= v[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) meta_s[0] <= in_meta;
		for (int i = 1; i < NS; i++) begin
			if (rdy[i]) meta_s[i] <= meta_s[i-1];
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [VW-1:0] xin;
		logic signed [VW-1:0] yin;
		logic signed [VW-1:0] fx;
		logic signed [VW-1:0] fy;
		logic signed [ANG_W-1:0] zf;
		logic signed [ANG_W-1:0] zc;

		assign xin = (l == 0) ? VW'(lx) : VW'(rx);
		assign yin = VW'(yv);
		// A vector pointing backwards is turned around by 180 degrees.
		assign fx = xin[VW-1] ? -xin : xin;
		assign fy = xin[VW-1] ? -yin : yin;

		always_ff @(posedge clk) begin
			if (rdy[0]) begin
				vx_s[l][0] <= fx;
				vy_s[l][0] <= fy;
				vz_s[l][0] <= '0;
				xz_s[l][0] <= (fx == '0);
				yz_s[l][0] <= (fy == '0);
			end
		end

		for (genvar j = 0; j < NI; j++) begin : g_it
			logic signed [ANG_W-1:0] at;
			logic                    ypos;
			assign at = $signed({{(ANG_W-32){1'b0}}, ATAN_TAB[j]});
			assign ypos = ~vy_s[l][j][VW-1] && (vy_s[l][j] != '0);
			always_ff @(posedge clk) begin
				if (rdy[j+1]) begin
					xz_s[l][j+1] <= xz_s[l][j];
					yz_s[l][j+1] <= yz_s[l][j];
					if (ypos) begin
						vx_s[l][j+1] <= vx_s[l][j] + (vy_s[l][j] >>> j);
						vy_s[l][j+1] <= vy_s[l][j] - (vx_s[l][j] >>> j);
						vz_s[l][j+1] <= vz_s[l][j] + at;
					end else begin
						vx_s[l][j+1] <= vx_s[l][j] - (vy_s[l][j] >>> j);
						vy_s[l][j+1] <= vy_s[l][j] + (vx_s[l][j] >>> j);
						vz_s[l][j+1] <= vz_s[l][j] - at;
					end
				end
			end
		end

		assign zf = vz_s[l][NI];
		always_comb begin
			if (zf > QUARTER_TURN) zc = QUARTER_TURN;
			else if (zf < -QUARTER_TURN) zc = -QUARTER_TURN;
			else zc = zf;
			// A vector on the y axis points straight sideways; a null vector
			// has no direction and reads as zero.
			if (xz_s[l][NI]) zc = yz_s[l][NI] ? '0 : QUARTER_TURN;
		end

		always_ff @(posedge clk) begin
			if (rdy[NS-1]) begin
				ang_s[l] <= zc;
				mag_s[l] <= vx_s[l][NI][VW-1] ? '0 : vx_s[l][NI];
			end
		end

		assign ang[l] = ang_s[l];
		assign mag[l] = mag_s[l];
	end

	assign out_meta = meta_s[NS-1];

endmodule

`default_nettype wire

// ===== design/ackss_speed.sv =====
// ----------------------------------------------------------------------------
// Servo and speed back end
// Turns the wheel angles into servo positions and divides the magnitudes
// into saturated motor duties with an eight stage restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ackss_speed import ackss_pkg::*; #(
	parameter int FRAC_BITS = 16,
	localparam int VW = FRAC_BITS + 20,
	localparam int PPW = VW + 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire meta_t              in_meta,
	input  wire logic signed [ANG_W-1:0] ang [2],
	input  wire logic [VW-1:0]      mag [2],
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              servo [4],
	output logic [7:0]              speed [2]
);

	localparam int NS = 10;

	logic [NS-1:0] v;
	logic [NS:0]   rdy;
	meta_t         meta_s1;

	logic [39:0]    dp_s1 [2];
	logic           dneg_s1 [2];
	logic [PPW-1:0] pp_s1 [2];
	logic [VW-1:0]  den_s1 [2];
	logic           numz_s1 [2];
	logic [6:0]     deg [2];

	logic [7:0]     sv_s [4][9];
	logic [7:0]     q_s [2][9];
	logic [PPW-1:0] rem_s [2][9];
	logic [VW-1:0]  dn_s [2][9];
	logic           done_s [2][9];

	assign rdy[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_rdy
		assign rdy[k] = ~v[k] | rdy[k+1];
	end
	assign in_ready = rdy[0];
	assign out_valid = v[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (rdy[0]) v[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				if (rdy[i]) v[i] <= v[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) meta_s1 <= in_meta;
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [30:0]    aabs;
		logic [40:0]    dr;
		logic [PPW-1:0] den8;
		logic [7:0]     fix;
		logic           done0;

		assign aabs = ang[l][ANG_W-1] ? 31'(-ang[l]) : 31'(ang[l]);
		assign dr = dp_s1[l] + DEG_HALF;
		assign deg[l] = dr[38:32];
		assign den8 = PPW'(den_s1[l]) << 8;

		always_comb begin
			done0 = 1'b1;
			if (meta_s1.straight) fix = meta_s1.thr;
			else if (den_s1[l] == '0) fix = numz_s1[l] ? meta_s1.thr : SPEED_SAT;
			else if (pp_s1[l] >= den8) fix = SPEED_SAT;
			else begin
				fix = '0;
				done0 = 1'b0;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[0]) begin
				dp_s1[l] <= aabs * DEG_SCALE;
				dneg_s1[l] <= ang[l][ANG_W-1];
				pp_s1[l] <= in_meta.thr * mag[l];
				den_s1[l] <= mag[1-l];
				numz_s1[l] <= (mag[l] == '0);
			end
			if (rdy[1]) begin
				q_s[l][0] <= fix;
				done_s[l][0] <= done0;
				rem_s[l][0] <= pp_s1[l];
				dn_s[l][0] <= den_s1[l];
			end
		end

		// One quotient bit per stage, most significant first.
		for (genvar j = 0; j < 8; j++) begin : g_div
			logic [PPW-1:0] dsh;
			logic           take;
			assign dsh = PPW'(dn_s[l][j]) << (7 - j);
			assign take = ~done_s[l][j] && (rem_s[l][j] >= dsh);
			always_ff @(posedge clk) begin
				if (rdy[j+2]) begin
					done_s[l][j+1] <= done_s[l][j];
					dn_s[l][j+1] <= dn_s[l][j];
					rem_s[l][j+1] <= take ? rem_s[l][j] - dsh : rem_s[l][j];
					q_s[l][j+1] <= take ? (q_s[l][j] | (8'd1 << (7 - j))) : q_s[l][j];
				end
			end
		end

		assign speed[l] = q_s[l][8];
	end

	// Servo order: front left, front right, back left, back right.
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			if (meta_s1.straight) begin
				for (int i = 0; i < 4; i++) sv_s[i][0] <= SERVO_CENTER;
			end else begin
				sv_s[0][0] <= dneg_s1[0] ? SERVO_CENTER + 8'(deg[0]) : SERVO_CENTER - 8'(deg[0]);
				sv_s[2][0] <= dneg_s1[0] ? SERVO_CENTER - 8'(deg[0]) : SERVO_CENTER + 8'(deg[0]);
				sv_s[1][0] <= dneg_s1[1] ? SERVO_CENTER - 8'(deg[1]) : SERVO_CENTER + 8'(deg[1]);
				sv_s[3][0] <= dneg_s1[1] ? SERVO_CENTER + 8'(deg[1]) : SERVO_CENTER - 8'(deg[1]);
			end
		end
		for (int j = 0; j < 8; j++) begin
			if (rdy[j+2]) begin
				for (int i = 0; i < 4; i++) sv_s[i][j+1] <= sv_s[i][j];
			end
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_sv
		assign servo[i] = sv_s[i][8];
	end

endmodule

`default_nettype wire

// ===== design/ackermann_steering_solver.sv =====
// ----------------------------------------------------------------------------
// Ackermann steering solver
// Steering angle and throttle in; four servo positions and two duties out.
// ----------------------------------------------------------------------------
// Usage:
// A request on cmd carries a signed steering angle in tenths of a degree and
// a throttle duty. The matching result on res carries the four wheel servo
// positions (90 is straight) and the left and right motor duties.
// Both channels use valid and ready; a transfer happens when both are high.
// An accepted request passes through the rotation CORDIC, the vectoring CORDIC
// and the speed divider in turn. One request can enter in every cycle while
// the pipeline is not stalled; this rate is set by the fully pipelined
// rotation and vectoring CORDICs and the eight stage speed divider.
// Every stage holds its own valid bit, so a stalled receiver only freezes the
// stages that are full; empty stages keep taking requests until the pipeline
// is packed, and nothing is dropped or repeated.
// Reset empties the pipeline and loads the axle offset 236 and the track
// offset 289 (1/64 inch). Write the geometry registers only while no request
// is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ackermann_steering_solver_assert.svh"

module ackermann_steering_solver import ackss_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ackss_cmd_if.sink        cmd,
	ackss_res_if.source      res,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);

	localparam int VIN_W = FRAC_BITS + 17;
	localparam int VW = VIN_W + 3;

	logic [11:0] axle_offset_q;
	logic [11:0] track_offset_q;

	// Geometry registers; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axle_offset_q <= AXLE_OFFSET_RST;
			track_offset_q <= TRACK_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AXLE_OFFSET: axle_offset_q <= cfg_data;
				REG_TRACK_OFFSET: track_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic                    rot_valid;
	logic                    rot_ready;
	meta_t                   rot_meta;
	logic signed [VIN_W-1:0] lx;
	logic signed [VIN_W-1:0] rx;
	logic signed [VIN_W-1:0] yv;

	logic                    vec_valid;
	logic                    vec_ready;
	meta_t                   vec_meta;
	logic signed [ANG_W-1:0] ang [2];
	logic [VW-1:0]           mag [2];

	logic [7:0] servo [4];
	logic [7:0] speed [2];

	// Turn center, sine-scaled: both wheel vectors from the rotation CORDIC.
	ackss_rotate #(
		.FRAC_BITS(FRAC_BITS),
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_rotate (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cmd.valid),
		.in_ready(cmd.ready),
		.steer_angle(cmd.steer_angle),
		.throttle(cmd.throttle),
		.axle_offset(axle_offset_q),
		.track_offset(track_offset_q),
		.out_valid(rot_valid),
		.out_ready(rot_ready),
		.out_meta(rot_meta),
		.lx(lx),
		.rx(rx),
		.yv(yv)
	);

	// Wheel angles and magnitudes, left and right lanes in parallel.
	ackss_vector #(
		.FRAC_BITS(FRAC_BITS),
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_vector (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(rot_valid),
		.in_ready(rot_ready),
		.in_meta(rot_meta),
		.lx(lx),
		.rx(rx),
		.yv(yv),
		.out_valid(vec_valid),
		.out_ready(vec_ready),
		.out_meta(vec_meta),
		.ang(ang),
		.mag(mag)
	);

	// Degrees, servo offsets and the magnitude ratio that scales throttle.
	// Its last stage is the output register of the block.
	ackss_speed #(
		.FRAC_BITS(FRAC_BITS)
	) u_speed (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vec_valid),
		.in_ready(vec_ready),
		.in_meta(vec_meta),
		.ang(ang),
		.mag(mag),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.servo(servo),
		.speed(speed)
	);

	assign res.front_left_servo = servo[0];
	assign res.front_right_servo = servo[1];
	assign res.back_left_servo = servo[2];
	assign res.back_right_servo = servo[3];
	assign res.left_duty = speed[0];
	assign res.right_duty = speed[1];

	// The back servos mirror the front servos about the center.
	`ACKSS_ASSERT_NOW(a_left_mirror, clk, arst_n, res.valid, 9'(res.front_left_servo) + 9'(res.back_left_servo) == 9'd180)
	`ACKSS_ASSERT_NOW(a_right_mirror, clk, arst_n, res.valid, 9'(res.front_right_servo) + 9'(res.back_right_servo) == 9'd180)
	`ACKSS_ASSERT_NOW(a_servo_range, clk, arst_n, res.valid, res.front_left_servo <= 8'd180 && res.front_right_servo <= 8'd180)

endmodule

`default_nettype wire
